[rtl/switch_state_multicast_confirm_assert.svh]
// assertion helpers used by the checker
`ifndef SWITCH_STATE_MULTICAST_CONFIRM_ASSERT_SVH
`define SWITCH_STATE_MULTICAST_CONFIRM_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SSMC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssmc same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define SSMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssmc next-cycle check failed");

`endif

[rtl/ssmc_pkg.sv]
`timescale 1ns / 1ps

package ssmc_pkg;

    // item function codes
    localparam logic [1:0] F_POLL    = 2'd0;
    localparam logic [1:0] F_CONFIRM = 2'd1;
    localparam logic [1:0] F_SLOT    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_MY_ADDR   = 3'd0;
    localparam logic [2:0] CFG_INV_ADDR  = 3'd1;
    localparam logic [2:0] CFG_INHIBIT   = 3'd2;
    localparam logic [2:0] CFG_RESPONSE  = 3'd3;
    localparam logic [2:0] CFG_WINDOW    = 3'd4;

    // configuration reset values
    localparam logic [7:0]  C_MY_ADDR_RST  = 8'd0;
    localparam logic [7:0]  C_INV_ADDR_RST = 8'hff;
    localparam logic [7:0]  C_INHIBIT_RST  = 8'd20;
    localparam logic [15:0] C_RESPONSE_RST = 16'd100;
    localparam logic [15:0] C_WINDOW_RST   = 16'd10000;

    // address store entries read as this until written
    localparam logic [7:0]  C_ADDR_RESET   = 8'hff;

    typedef enum logic [2:0] {
        ST_INIT  = 3'd0,
        ST_SKIP  = 3'd1,
        ST_WAIT1 = 3'd2,
        ST_WAIT2 = 3'd3,
        ST_OK    = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0]  addr;
        t_status     status;
        logic [15:0] stamp;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CF_SCAN,
        S_P_CHK,
        S_P_COPY,
        S_P_RUN,
        S_P_CUR,
        S_P_SCAN,
        S_DONE
    } t_state;

endpackage

[rtl/ssmc_cmp.sv]
`timescale 1ns / 1ps

// shared elapsed-time compare: (a - b) mod 2^16 >= limit, optionally on low byte only
module ssmc_cmp
    import ssmc_pkg::*;
(
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    input  logic [15:0] i_limit,
    input  logic        i_low8,
    output logic        o_ge
);

    logic [15:0] w_diff;

    assign w_diff = i_a - i_b;

    always_comb begin
        if (i_low8) begin
            o_ge = (w_diff[7:0] >= i_limit[7:0]);
        end else begin
            o_ge = (w_diff >= i_limit);
        end
    end

endmodule

[rtl/ssmc_store.sv]
`timescale 1ns / 1ps

// address store and client table, one write and one registered read each
module ssmc_store
    import ssmc_pkg::*;
#(
    parameter int CLIENTS = 16,
    parameter int IDXW    = 4
)
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [IDXW-1:0] i_rd_addr,
    input  logic            i_rec_we,
    input  logic [IDXW-1:0] i_rec_waddr,
    input  t_rec            i_rec_wdata,
    output t_rec            o_rec,
    input  logic            i_as_we,
    input  logic [IDXW-1:0] i_as_waddr,
    input  logic [7:0]      i_as_wdata,
    output logic [7:0]      o_as
);

    t_rec               r_rec_mem [CLIENTS];
    logic [7:0]         r_as_mem  [CLIENTS];
    logic [CLIENTS-1:0] r_as_val;
    t_rec               r_rec_q;
    logic [7:0]         r_as_q;
    logic               r_as_vq;

    always_ff @(posedge i_clk) begin
        if (i_rec_we) begin
            r_rec_mem[i_rec_waddr] <= i_rec_wdata;
        end
        r_rec_q <= r_rec_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_as_we) begin
            r_as_mem[i_as_waddr] <= i_as_wdata;
        end
        r_as_q <= r_as_mem[i_rd_addr];
    end

    // per-entry written flags, unwritten entries read as the reset address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_as_val <= '0;
            r_as_vq  <= 1'b0;
        end else begin
            if (i_as_we) begin
                r_as_val[i_as_waddr] <= 1'b1;
            end
            r_as_vq <= r_as_val[i_rd_addr];
        end
    end

    assign o_rec = r_rec_q;
    assign o_as  = r_as_vq ? r_as_q : C_ADDR_RESET;

endmodule

[rtl/switch_state_multicast_confirm.sv]
`timescale 1ns / 1ps

// Switch-state multicast with confirmation. Each poll transaction carries the
// switch state and the millisecond time; a changed state (or the very first
// poll) copies the address store into the client table and starts a round in
// which clients are served one at a time: a request goes out (o_send_valid),
// then an inhibit wait, then a response wait, and clients that do not confirm
// are retried round-robin until the retry window since the change is over.
// Confirmation transactions mark the first matching waiting client done, and
// slot transactions write the address store. Every input transaction yields
// exactly one output transaction carrying the request (if any), the busy flag
// and the slot being served (CLIENTS means none). The block works on one
// transaction at a time and holds o_in_stall high meanwhile: a slot write or
// unused function goes straight to the output stage, a confirmation scans
// the client table, and a poll may copy the table and search it for the next
// client. The client table has a single read port; the copy and the searches
// visit one slot per cycle. Configuration writes are always taken (o_cfg_ready
// is 1) and must only be issued while no transaction is in flight.
module switch_state_multicast_confirm
    import ssmc_pkg::*;
#(
    parameter int CLIENTS = 16,
    localparam int IW     = $clog2(CLIENTS + 1)
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,

    // input transactions
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_func,
    input  logic [7:0]    i_switch_state,
    input  logic [15:0]   i_now_ms,
    input  logic [7:0]    i_peer_address,
    input  logic [7:0]    i_receiver_address,
    input  logic [7:0]    i_confirmed_state,
    input  logic [3:0]    i_slot_index,
    input  logic [7:0]    i_slot_address,

    // output transactions
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_send_valid,
    output logic [7:0]    o_send_receiver,
    output logic [7:0]    o_send_sender,
    output logic [7:0]    o_send_state,
    output logic          o_busy_res,
    output logic [IW-1:0] o_current_client,

    // configuration writes
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);

    localparam int IDXW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CLIENTS - 1);
    localparam logic [IW-1:0]   NO_CLIENT = IW'(CLIENTS);
    localparam logic [IW-1:0]   LAST_CNT  = IW'(CLIENTS - 1);

    // configuration registers
    logic [7:0]  r_my;
    logic [7:0]  r_inv;
    logic [7:0]  r_inh;
    logic [15:0] r_resp;
    logic [15:0] r_win;

    // sequencer state
    t_state          r_state, n_state;
    logic [IDXW-1:0] r_ptr, n_ptr;
    logic [IW-1:0]   r_cnt, n_cnt;
    logic [IW-1:0]   r_serving, n_serving;
    logic            r_act_after, n_act_after;
    logic            r_send, n_send;
    logic [7:0]      r_rcv, n_rcv;

    // round state
    logic [7:0]  r_prev, n_prev;
    logic        r_known, n_known;
    logic [7:0]  r_round, n_round;
    logic [15:0] r_chg, n_chg;
    logic        r_tbl_init, n_tbl_init;

    // latched item fields
    logic [7:0]  r_sw;
    logic [15:0] r_now;
    logic [7:0]  r_peer;

    // output register
    logic          r_ov;
    logic          r_o_send;
    logic [7:0]    r_o_rcv;
    logic [7:0]    r_o_sender;
    logic [7:0]    r_o_state;
    logic          r_o_busy;
    logic [IW-1:0] r_o_cur;

    // table interface
    logic            w_rec_we;
    t_rec            w_rec_wdata;
    t_rec            w_rec;
    logic [7:0]      w_as;
    logic            w_as_we;
    t_status         w_stat;

    // shared compare unit operands
    logic [15:0] w_cmp_b;
    logic [15:0] w_cmp_limit;
    logic        w_cmp_low8;
    logic        w_ge;

    logic            w_in_acc;
    logic            w_out_load;
    logic            w_changed;
    logic            w_do_act;
    logic [IDXW-1:0] w_ptr_next;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_load = (r_state == S_DONE) && (!r_ov || !i_out_stall);
    assign w_changed  = !r_known || (i_switch_state != r_prev);
    assign w_ptr_next = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;

    // table entries before the first round read as skipped
    assign w_stat = r_tbl_init ? w_rec.status : ST_SKIP;

    // slot writes happen in the accept cycle
    assign w_as_we = w_in_acc && (i_func == F_SLOT) && (int'(i_slot_index) < CLIENTS);

    ssmc_store #(
        .CLIENTS (CLIENTS),
        .IDXW    (IDXW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (n_ptr),
        .i_rec_we    (w_rec_we),
        .i_rec_waddr (r_ptr),
        .i_rec_wdata (w_rec_wdata),
        .o_rec       (w_rec),
        .i_as_we     (w_as_we),
        .i_as_waddr  (IDXW'(i_slot_index)),
        .i_as_wdata  (i_slot_address),
        .o_as        (w_as)
    );

    // window check in the run step, per-client waits otherwise
    always_comb begin
        if (r_state == S_P_RUN) begin
            w_cmp_b     = r_chg;
            w_cmp_limit = r_win;
            w_cmp_low8  = 1'b0;
        end else begin
            w_cmp_b     = w_rec.stamp;
            w_cmp_limit = (w_stat == ST_WAIT1) ? {8'd0, r_inh} : r_resp;
            w_cmp_low8  = (w_stat == ST_WAIT1);
        end
    end

    ssmc_cmp u_cmp (
        .i_a     (r_now),
        .i_b     (w_cmp_b),
        .i_limit (w_cmp_limit),
        .i_low8  (w_cmp_low8),
        .o_ge    (w_ge)
    );

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my   <= C_MY_ADDR_RST;
            r_inv  <= C_INV_ADDR_RST;
            r_inh  <= C_INHIBIT_RST;
            r_resp <= C_RESPONSE_RST;
            r_win  <= C_WINDOW_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MY_ADDR:  r_my   <= i_cfg_data[7:0];
                CFG_INV_ADDR: r_inv  <= i_cfg_data[7:0];
                CFG_INHIBIT:  r_inh  <= i_cfg_data[7:0];
                CFG_RESPONSE: r_resp <= i_cfg_data;
                CFG_WINDOW:   r_win  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item fields used after the accept cycle
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sw   <= i_switch_state;
            r_now  <= i_now_ms;
            r_peer <= i_peer_address;
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_serving   <= NO_CLIENT;
            r_act_after <= 1'b0;
            r_send      <= 1'b0;
            r_rcv       <= 8'd0;
            r_prev      <= 8'd0;
            r_known     <= 1'b0;
            r_round     <= 8'd0;
            r_chg       <= 16'd0;
            r_tbl_init  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_serving   <= n_serving;
            r_act_after <= n_act_after;
            r_send      <= n_send;
            r_rcv       <= n_rcv;
            r_prev      <= n_prev;
            r_known     <= n_known;
            r_round     <= n_round;
            r_chg       <= n_chg;
            r_tbl_init  <= n_tbl_init;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_serving   = r_serving;
        n_act_after = r_act_after;
        n_send      = r_send;
        n_rcv       = r_rcv;
        n_prev      = r_prev;
        n_known     = r_known;
        n_round     = r_round;
        n_chg       = r_chg;
        n_tbl_init  = r_tbl_init;
        w_rec_we    = 1'b0;
        w_rec_wdata = '{addr: w_rec.addr, status: w_rec.status, stamp: w_rec.stamp};
        w_do_act    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_send = 1'b0;
                    case (i_func)
                        F_POLL: begin
                            if (w_changed && (r_serving != NO_CLIENT)) begin
                                // look at the served client: no restart during inhibit
                                n_ptr   = r_serving[IDXW-1:0];
                                n_state = S_P_CHK;
                            end else if (w_changed) begin
                                n_ptr   = '0;
                                n_state = S_P_COPY;
                            end else begin
                                n_state = S_P_RUN;
                            end
                        end
                        F_CONFIRM: begin
                            if ((i_receiver_address == r_my) &&
                                (i_confirmed_state == r_round)) begin
                                n_ptr   = '0;
                                n_state = S_CF_SCAN;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_CF_SCAN: begin
                // first waiting client with the sender address is marked done
                if (((w_stat == ST_WAIT1) || (w_stat == ST_WAIT2)) &&
                    (w_rec.addr == r_peer)) begin
                    w_rec_we    = 1'b1;
                    w_rec_wdata = '{addr: w_rec.addr, status: ST_OK, stamp: w_rec.stamp};
                    n_state     = S_DONE;
                end else if (r_ptr == LAST_IDX) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr = w_ptr_next;
                end
            end

            S_P_CHK: begin
                if (w_stat == ST_WAIT1) begin
                    // deferred, the change shows again at the next poll
                    n_state = S_P_RUN;
                end else begin
                    n_ptr   = '0;
                    n_state = S_P_COPY;
                end
            end

            S_P_COPY: begin
                // latch one slot a cycle, invalid addresses are skipped
                w_rec_we    = 1'b1;
                w_rec_wdata = '{addr: w_as,
                                status: (w_as != r_inv) ? ST_INIT : ST_SKIP,
                                stamp: r_now};
                if (r_ptr == LAST_IDX) begin
                    n_prev     = r_sw;
                    n_known    = 1'b1;
                    n_round    = r_sw;
                    n_chg      = r_now;
                    n_serving  = '0;
                    n_tbl_init = 1'b1;
                    n_state    = S_P_RUN;
                end else begin
                    n_ptr = w_ptr_next;
                end
            end

            S_P_RUN: begin
                if (r_serving == NO_CLIENT) begin
                    n_state = S_DONE;
                end else if (w_ge) begin
                    // retry window over, round ends
                    n_serving = NO_CLIENT;
                    n_state   = S_DONE;
                end else begin
                    n_ptr   = r_serving[IDXW-1:0];
                    n_state = S_P_CUR;
                end
            end

            S_P_CUR: begin
                if ((w_stat == ST_OK) || (w_stat == ST_SKIP)) begin
                    // current slot already done or unused: find the next one first
                    n_cnt       = '0;
                    n_ptr       = w_ptr_next;
                    n_act_after = 1'b0;
                    n_state     = S_P_SCAN;
                end else begin
                    w_do_act = 1'b1;
                end
            end

            S_P_SCAN: begin
                if ((w_stat != ST_OK) && (w_stat != ST_SKIP)) begin
                    n_serving = IW'(r_ptr);
                    if (r_act_after) begin
                        n_state = S_DONE;
                    end else begin
                        w_do_act = 1'b1;
                    end
                end else if (r_cnt == LAST_CNT) begin
                    n_serving = NO_CLIENT;
                    n_state   = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    n_ptr = w_ptr_next;
                end
            end

            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // serve the client at r_ptr
        if (w_do_act) begin
            case (w_stat)
                ST_INIT: begin
                    n_send      = 1'b1;
                    n_rcv       = w_rec.addr;
                    w_rec_we    = 1'b1;
                    w_rec_wdata = '{addr: w_rec.addr, status: ST_WAIT1, stamp: r_now};
                    n_state     = S_DONE;
                end
                ST_WAIT1: begin
                    if (w_ge) begin
                        w_rec_we    = 1'b1;
                        w_rec_wdata = '{addr: w_rec.addr, status: ST_WAIT2, stamp: r_now};
                    end
                    n_state = S_DONE;
                end
                ST_WAIT2: begin
                    if (w_ge) begin
                        // no answer: back to init and move to the next client
                        w_rec_we    = 1'b1;
                        w_rec_wdata = '{addr: w_rec.addr, status: ST_INIT,
                                        stamp: w_rec.stamp};
                        n_act_after = 1'b1;
                        n_cnt       = '0;
                        n_ptr       = w_ptr_next;
                        n_state     = S_P_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
                default: begin
                    n_state = S_DONE;
                end
            endcase
        end
    end

    // output register, frees the sequencer while the result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_load) begin
            r_ov <= 1'b1;
        end else if (r_ov && !i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_send   <= r_send;
            r_o_rcv    <= r_send ? r_rcv : 8'd0;
            r_o_sender <= r_send ? r_my : 8'd0;
            r_o_state  <= r_send ? r_round : 8'd0;
            r_o_busy   <= (r_serving != NO_CLIENT);
            r_o_cur    <= r_serving;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_ov;
    assign o_send_valid     = r_o_send;
    assign o_send_receiver  = r_o_rcv;
    assign o_send_sender    = r_o_sender;
    assign o_send_state     = r_o_state;
    assign o_busy_res       = r_o_busy;
    assign o_current_client = r_o_cur;

endmodule

[rtl/ssmc_checker.sv]
`timescale 1ns / 1ps

`include "switch_state_multicast_confirm_assert.svh"

module ssmc_checker #(
    parameter int CLIENTS = 16,
    localparam int IW     = $clog2(CLIENTS + 1)
)
(
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input logic          o_send_valid,
    input logic [7:0]    o_send_receiver,
    input logic [7:0]    o_send_sender,
    input logic [7:0]    o_send_state,
    input logic          o_busy_res,
    input logic [IW-1:0] o_current_client
);

    // a stalled result stays
    `SSMC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_current_client) && $stable(o_send_receiver))

    // no request means an all-zero telegram
    `SSMC_ASSERT_SAME(a_no_send_zero, i_clk, i_rst_n, o_out_valid && !o_send_valid, (o_send_receiver == 8'd0) && (o_send_sender == 8'd0) && (o_send_state == 8'd0))

    // busy agrees with the served slot, which never exceeds the none code
    `SSMC_ASSERT_SAME(a_busy_slot, i_clk, i_rst_n, o_out_valid, (o_busy_res == (o_current_client != IW'(CLIENTS))) && (o_current_client <= IW'(CLIENTS)))

    // every accepted transaction raises o_in_stall in the following cycle
    `SSMC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind switch_state_multicast_confirm ssmc_checker #(.CLIENTS(CLIENTS)) u_ssmc_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ssmc_pkg::*;

    localparam int NCLIENTS      = 16;
    // settle time after the last result, with room above the slowest poll
    localparam int SETTLE_CYCLES = 4 * NCLIENTS + 16;
    // the slowest correct run is roughly 1400 transactions
    localparam int LIMIT_CYCLES  = 1000000;

    // function code that the block has to ignore
    localparam logic [1:0] F_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  switch_state;
        logic [15:0] now_ms;
        logic [7:0]  peer_address;
        logic [7:0]  receiver_address;
        logic [7:0]  confirmed_state;
        logic [3:0]  slot_index;
        logic [7:0]  slot_address;
    } t_item;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_receiver;
        logic [7:0]  send_sender;
        logic [7:0]  send_state;
        logic        busy;
        logic [4:0]  current_client;
    } t_telegram;

    typedef struct {
        t_item     it;
        bit        typed;
        t_telegram tg;
    } t_row;

    typedef struct {
        logic [7:0]  my_addr;
        logic [7:0]  inv_addr;
        logic [7:0]  inhibit;
        logic [15:0] response;
        logic [15:0] window;
        int          step_max;
        int          change_odds;
        int          items;
        bit          shuffle;
    } t_phase;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    localparam t_telegram UNCHECKED     = '0;
    localparam t_telegram NO_ROUND      = '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd16};
    localparam t_telegram FIRST_REQUEST = '{1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 5'd0};

    logic          i_clk;
    logic          i_rst_n            = 1'b0;
    logic          i_in_valid         = 1'b0;
    logic          o_in_stall;
    logic [1:0]    i_func             = F_POLL;
    logic [7:0]    i_switch_state     = 8'h00;
    logic [15:0]   i_now_ms           = 16'h0000;
    logic [7:0]    i_peer_address     = 8'h00;
    logic [7:0]    i_receiver_address = 8'h00;
    logic [7:0]    i_confirmed_state  = 8'h00;
    logic [3:0]    i_slot_index       = 4'h0;
    logic [7:0]    i_slot_address     = 8'h00;
    logic          o_out_valid;
    logic          i_out_stall        = 1'b0;
    logic          o_send_valid;
    logic [7:0]    o_send_receiver;
    logic [7:0]    o_send_sender;
    logic [7:0]    o_send_state;
    logic          o_busy_res;
    logic [4:0]    o_current_client;
    logic          i_cfg_valid        = 1'b0;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index        = CFG_MY_ADDR;
    logic [15:0]   i_cfg_data         = 16'h0000;

    switch_state_multicast_confirm #(
        .CLIENTS(NCLIENTS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_switch_state     (i_switch_state),
        .i_now_ms           (i_now_ms),
        .i_peer_address     (i_peer_address),
        .i_receiver_address (i_receiver_address),
        .i_confirmed_state  (i_confirmed_state),
        .i_slot_index       (i_slot_index),
        .i_slot_address     (i_slot_address),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_send_valid       (o_send_valid),
        .o_send_receiver    (o_send_receiver),
        .o_send_sender      (o_send_sender),
        .o_send_state       (o_send_state),
        .o_busy_res         (o_busy_res),
        .o_current_client   (o_current_client),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // multicast predictor: own copy of registers, address store and round
    // ------------------------------------------------------------------
    logic [7:0]  p_my_addr;
    logic [7:0]  p_inv_addr;
    logic [7:0]  p_inhibit;
    logic [15:0] p_response;
    logic [15:0] p_window;

    logic [7:0]  p_store       [NCLIENTS];
    logic [7:0]  p_client_addr [NCLIENTS];
    t_status     p_status      [NCLIENTS];
    logic [15:0] p_stamp       [NCLIENTS];
    int unsigned p_serving;
    logic [7:0]  p_prev_state;
    bit          p_prev_known;
    logic [7:0]  p_round_state;
    logic [15:0] p_change_stamp;

    t_telegram   telegram_q [$];

    int          mismatches      = 0;
    int          results_checked = 0;
    int          rounds_started  = 0;
    int          requests_sent   = 0;
    int          confirms_taken  = 0;
    int unsigned cycle_count     = 0;

    // sender and receiver pacing
    int          burst_left  = 0;
    t_rx_mode    rx_mode     = RX_OPEN;
    int          rx_left     = 0;

    // random stimulus context
    logic [15:0] clock_ms     = 16'd200;
    logic [7:0]  switch_level = 8'h00;
    int          step_max     = 12;
    int          change_odds  = 30;

    task automatic reset_multicast_model();
        p_my_addr      = C_MY_ADDR_RST;
        p_inv_addr     = C_INV_ADDR_RST;
        p_inhibit      = C_INHIBIT_RST;
        p_response     = C_RESPONSE_RST;
        p_window       = C_WINDOW_RST;
        for (int i = 0; i < NCLIENTS; i++) begin
            p_store[i]       = C_ADDR_RESET;
            p_client_addr[i] = 8'h00;
            p_status[i]      = ST_SKIP;
            p_stamp[i]       = 16'h0000;
        end
        p_serving      = NCLIENTS;
        p_prev_state   = 8'h00;
        p_prev_known   = 1'b0;
        p_round_state  = 8'h00;
        p_change_stamp = 16'h0000;
    endtask

    // next slot after start_slot, round-robin, that is neither skipped nor confirmed
    function automatic int unsigned next_open_slot(int unsigned start_slot);
        int unsigned n;
        if (start_slot >= NCLIENTS)
            return NCLIENTS;
        for (int i = 0; i < NCLIENTS; i++) begin
            n = (start_slot + i + 1) % NCLIENTS;
            if (p_status[n] != ST_SKIP && p_status[n] != ST_OK)
                return n;
        end
        return NCLIENTS;
    endfunction

    task automatic predict_telegram(input t_item it, output t_telegram tg);
        bit          sent;
        logic [7:0]  rcv;
        logic [15:0] elapsed;
        int unsigned cur;
        sent = 1'b0;
        rcv  = 8'h00;
        case (it.func)
            F_POLL: begin
                // a new state waits while the served client is in its inhibit wait
                if ((!p_prev_known || it.switch_state != p_prev_state) &&
                    !(p_serving < NCLIENTS && p_status[p_serving] == ST_WAIT1)) begin
                    p_prev_state   = it.switch_state;
                    p_prev_known   = 1'b1;
                    p_round_state  = it.switch_state;
                    p_change_stamp = it.now_ms;
                    p_serving      = 0;
                    rounds_started++;
                    for (int i = 0; i < NCLIENTS; i++) begin
                        p_client_addr[i] = p_store[i];
                        p_status[i]      = (p_store[i] != p_inv_addr) ? ST_INIT : ST_SKIP;
                    end
                end
                if (p_serving < NCLIENTS) begin
                    elapsed = it.now_ms - p_change_stamp;
                    if (elapsed >= p_window) begin
                        p_serving = NCLIENTS;
                    end else begin
                        if (p_status[p_serving] == ST_OK || p_status[p_serving] == ST_SKIP)
                            p_serving = next_open_slot(p_serving);
                        if (p_serving < NCLIENTS) begin
                            cur = p_serving;
                            case (p_status[cur])
                                ST_INIT: begin
                                    sent          = 1'b1;
                                    rcv           = p_client_addr[cur];
                                    p_status[cur] = ST_WAIT1;
                                    p_stamp[cur]  = it.now_ms;
                                    requests_sent++;
                                end
                                ST_WAIT1: begin
                                    // only the low byte of the elapsed time counts here
                                    elapsed = it.now_ms - p_stamp[cur];
                                    if (elapsed[7:0] >= p_inhibit) begin
                                        p_status[cur] = ST_WAIT2;
                                        p_stamp[cur]  = it.now_ms;
                                    end
                                end
                                ST_WAIT2: begin
                                    elapsed = it.now_ms - p_stamp[cur];
                                    if (elapsed >= p_response) begin
                                        p_status[cur] = ST_INIT;
                                        p_serving     = next_open_slot(cur);
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            F_CONFIRM: begin
                if (it.receiver_address == p_my_addr) begin
                    for (int i = 0; i < NCLIENTS; i++) begin
                        if (p_status[i] != ST_SKIP && p_client_addr[i] == it.peer_address &&
                            it.confirmed_state == p_round_state &&
                            (p_status[i] == ST_WAIT1 || p_status[i] == ST_WAIT2)) begin
                            p_status[i] = ST_OK;
                            confirms_taken++;
                            break;
                        end
                    end
                end
            end
            F_SLOT: p_store[it.slot_index] = it.slot_address;
            default: ;
        endcase
        tg.send_valid     = sent;
        tg.send_receiver  = sent ? rcv : 8'h00;
        tg.send_sender    = sent ? p_my_addr : 8'h00;
        tg.send_state     = sent ? p_round_state : 8'h00;
        tg.busy           = (p_serving < NCLIENTS);
        tg.current_client = 5'(p_serving);
    endtask

    // ------------------------------------------------------------------
    // clock, timeout and receiver stall pattern
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, telegram_q.size());
            $display("** switch_state_multicast_confirm: FAILED **");
            $finish;
        end
    end

    // receiver switches between open, light, heavy and periodic stalling
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(10, 150);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  i_out_stall <= 1'b0;
            RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:  i_out_stall <= cycle_count[2];
        endcase
    end

    // ------------------------------------------------------------------
    // result checking: every output transaction against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : telegram_check
        t_telegram want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (telegram_q.size() == 0) begin
                $error("output transaction with no expectation waiting");
                mismatches++;
            end else begin
                want = telegram_q.pop_front();
                results_checked++;
                check_field("send_valid",     16'(want.send_valid),     16'(o_send_valid));
                check_field("send_receiver",  16'(want.send_receiver),  16'(o_send_receiver));
                check_field("send_sender",    16'(want.send_sender),    16'(o_send_sender));
                check_field("send_state",     16'(want.send_state),     16'(o_send_state));
                check_field("busy_res",       16'(want.busy),           16'(o_busy_res));
                check_field("current_client", 16'(want.current_client),
                            16'(o_current_client));
            end
        end
    end

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // drive one transaction, wait for it to be taken, then record what it should yield;
    // valid stays up inside a burst so back-to-back transactions really happen
    task automatic send_item(input t_item it, input bit typed, input t_telegram typed_tg);
        t_telegram tg;
        i_in_valid         <= 1'b1;
        i_func             <= it.func;
        i_switch_state     <= it.switch_state;
        i_now_ms           <= it.now_ms;
        i_peer_address     <= it.peer_address;
        i_receiver_address <= it.receiver_address;
        i_confirmed_state  <= it.confirmed_state;
        i_slot_index       <= it.slot_index;
        i_slot_address     <= it.slot_address;
        do @(posedge i_clk); while (o_in_stall);
        predict_telegram(it, tg);
        telegram_q.push_back(typed ? typed_tg : tg);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // sender holds off until the block has answered everything
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (telegram_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MY_ADDR:  p_my_addr  = data[7:0];
            CFG_INV_ADDR: p_inv_addr = data[7:0];
            CFG_INHIBIT:  p_inhibit  = data[7:0];
            CFG_RESPONSE: p_response = data;
            CFG_WINDOW:   p_window   = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly well-formed traffic: polls on a running ms clock with occasional
    // state changes, confirmations from the client being served, slot writes
    // from a small address pool so that duplicates and unused slots show up
    task automatic make_random_item(output t_item it);
        logic [63:0] noise;
        int unsigned pick;
        noise = {$urandom, $urandom};
        it    = noise[61:0];
        pick  = $urandom_range(0, 99);
        if (pick < 55) begin
            it.func = F_POLL;
            // a rare long jump makes the elapsed-time arithmetic wrap
            if ($urandom_range(0, 199) == 0)
                clock_ms = clock_ms + 16'($urandom);
            else
                clock_ms = clock_ms + 16'($urandom_range(0, step_max));
            if ($urandom_range(1, change_odds) == 1)
                switch_level = $urandom_range(0, 1) ? 8'($urandom)
                                                    : switch_level ^ (8'h01 << $urandom_range(0, 7));
            it.switch_state = switch_level;
            it.now_ms       = clock_ms;
        end else if (pick < 82) begin
            it.func = F_CONFIRM;
            // three in ten stay pure noise
            if ($urandom_range(0, 9) < 7) begin
                it.peer_address     = (p_serving < NCLIENTS) ? p_client_addr[p_serving]
                                                             : p_store[$urandom_range(0, NCLIENTS - 1)];
                it.receiver_address = p_my_addr;
                it.confirmed_state  = p_round_state;
                // broken confirmation: one field off by a bit
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 2))
                        0: it.peer_address     = it.peer_address ^ (8'h01 << $urandom_range(0, 7));
                        1: it.receiver_address = it.receiver_address ^ (8'h01 << $urandom_range(0, 7));
                        default: it.confirmed_state = it.confirmed_state ^ (8'h01 << $urandom_range(0, 7));
                    endcase
                end
            end
        end else if (pick < 96) begin
            it.func = F_SLOT;
            case ($urandom_range(0, 3))
                0:       it.slot_address = p_inv_addr;
                1, 2:    it.slot_address = 8'h10 + 8'($urandom_range(0, 5));
                default: ;
            endcase
        end else begin
            it.func = F_UNUSED;
        end
    endtask

    // ------------------------------------------------------------------
    // directed table, run at reset settings: my 0, unused 0xff, 20 / 100 / 10000 ms
    // ------------------------------------------------------------------
    t_row directed_rows [25] = '{
        // unused function with every field at its top value
        '{'{F_UNUSED, 8'hff, 16'hffff, 8'hff, 8'hff, 8'hff, 4'hf, 8'hff}, 1'b1, NO_ROUND},
        // confirmation with every slot skipped
        '{'{F_CONFIRM, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b1, NO_ROUND},
        '{'{F_SLOT, 8'h5a, 16'h1234, 8'ha5, 8'h3c, 8'hc3, 4'h0, 8'h00}, 1'b1, NO_ROUND},
        '{'{F_SLOT, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 4'hf, 8'hfe}, 1'b1, NO_ROUND},
        '{'{F_SLOT, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 4'h5, 8'h42}, 1'b1, NO_ROUND},
        // first poll opens a round although the state equals the reset state
        '{'{F_POLL, 8'h00, 16'd0, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b1, FIRST_REQUEST},
        '{'{F_POLL, 8'h00, 16'd5, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        // change arrives in the inhibit wait: deferred, twice
        '{'{F_POLL, 8'hff, 16'd10, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        '{'{F_POLL, 8'hff, 16'd25, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        '{'{F_POLL, 8'hff, 16'd30, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        '{'{F_CONFIRM, 8'h00, 16'd0, 8'h00, 8'h00, 8'hff, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        // served slot already confirmed: moves on to the next client
        '{'{F_POLL, 8'hff, 16'd31, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        // confirmations that must not match: wrong receiver, state, sender
        '{'{F_CONFIRM, 8'h00, 16'd0, 8'h42, 8'h01, 8'hff, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        '{'{F_CONFIRM, 8'h00, 16'd0, 8'h42, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        '{'{F_CONFIRM, 8'h00, 16'd0, 8'h77, 8'h00, 8'hff, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        '{'{F_POLL, 8'hff, 16'd60, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        // response wait runs out: next client
        '{'{F_POLL, 8'hff, 16'd160, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        '{'{F_POLL, 8'hff, 16'd161, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        '{'{F_SLOT, 8'h00, 16'd0, 8'h00, 8'h00, 8'h00, 4'h0, 8'hff}, 1'b0, UNCHECKED},
        // retry window over: round stops
        '{'{F_POLL, 8'hff, 16'hffff, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b1, NO_ROUND},
        '{'{F_POLL, 8'hff, 16'd0, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        // new round with slot 0 skipped from the start
        '{'{F_POLL, 8'h00, 16'd100, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        '{'{F_POLL, 8'h00, 16'd100, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        '{'{F_CONFIRM, 8'h00, 16'd0, 8'h42, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED},
        '{'{F_UNUSED, 8'h00, 16'd0, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00}, 1'b0, UNCHECKED}
    };

    // register settings for the random part, extremes included
    localparam int NPHASES = 6;
    t_phase phase_plan [NPHASES] = '{
        // reset-like timing with a long retry window
        '{8'h00, 8'hff, 8'd20,  16'd100,   16'd10000, 12,  30, 300, 1'b0},
        // every timer at zero: each round ends on its first poll
        '{8'hff, 8'h00, 8'd0,   16'd0,     16'd0,     4,   6,  80,  1'b0},
        // zero waits, widest window: fast round-robin retries
        '{8'h01, 8'h00, 8'd0,   16'd0,     16'd65535, 3,   20, 200, 1'b0},
        // longest waits, coarse time steps
        '{8'h3c, 8'hff, 8'd255, 16'd65535, 16'd65535, 300, 25, 200, 1'b0},
        // short window so rounds time out while clients are retried
        '{8'h5a, 8'h80, 8'd3,   16'd10,    16'd300,   6,   50, 250, 1'b0},
        // drawn at run time
        '{8'h00, 8'h00, 8'd0,   16'd0,     16'd0,     15,  20, 300, 1'b1}
    };

    initial begin : stimulus
        t_phase ph;
        t_item  it;
        reset_multicast_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].tg);

        for (int p = 0; p < NPHASES; p++) begin
            ph = phase_plan[p];
            if (ph.shuffle) begin
                ph.my_addr  = 8'($urandom);
                ph.inv_addr = 8'($urandom);
                ph.inhibit  = 8'($urandom_range(0, 40));
                ph.response = 16'($urandom_range(0, 200));
                ph.window   = 16'($urandom_range(100, 5000));
            end
            // registers only change with the block idle
            wait_for_results();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            write_register(CFG_MY_ADDR,  {8'($urandom), ph.my_addr});
            write_register(CFG_INV_ADDR, {8'($urandom), ph.inv_addr});
            write_register(CFG_INHIBIT,  {8'($urandom), ph.inhibit});
            write_register(CFG_RESPONSE, ph.response);
            write_register(CFG_WINDOW,   ph.window);
            step_max    = ph.step_max;
            change_odds = ph.change_odds;
            for (int n = 0; n < ph.items; n++) begin
                make_random_item(it);
                send_item(it, 1'b0, UNCHECKED);
                if ($urandom_range(0, 149) == 0)
                    wait_for_results();
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions over %0d register settings plus reset values",
                 results_checked, NPHASES);
        $display("rounds opened %0d, requests sent %0d, confirmations taken %0d",
                 rounds_started, requests_sent, confirms_taken);
        if (mismatches == 0)
            $display("** switch_state_multicast_confirm: PASSED **");
        else
            $display("** switch_state_multicast_confirm: FAILED **");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/ssmc_pkg.sv
rtl/ssmc_cmp.sv
rtl/ssmc_store.sv
rtl/switch_state_multicast_confirm.sv
rtl/ssmc_checker.sv
test/tb_top.sv
